### hw/rtl/bpa_pkg.sv
// Shared constants and types of the bitmap page allocator.
`timescale 1ns / 1ps

package bpa_pkg;

  localparam int PAGES_DEF      = 1024;
  localparam int WORD_BITS_DEF  = 32;
  localparam int PAGE_SHIFT_DEF = 12;

  localparam int MODE_W    = 2;
  localparam int ADDR_W    = 32;
  localparam int CNT_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INIT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MANAGED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd1;

  localparam logic [CNT_W-1:0] RST_MANAGED  = 11'd1024;
  localparam logic [CNT_W-1:0] RST_RESERVED = 11'd256;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_FREE_WR,
    S_DONE
  } state_t;

endpackage

### hw/rtl/bpa_if.sv
// Channel interfaces of the bitmap page allocator: requests, results and configuration.
`timescale 1ns / 1ps

interface bpa_in_if;
  logic                             valid;
  logic                             ready;
  logic [bpa_pkg::MODE_W-1:0]       mode;
  logic [bpa_pkg::ADDR_W-1:0]       free_addr;
  modport source (output valid, mode, free_addr, input ready);
  modport sink   (input valid, mode, free_addr, output ready);
endinterface

interface bpa_out_if;
  logic                             valid;
  logic                             ready;
  logic [bpa_pkg::ADDR_W-1:0]       result_addr;
  logic                             success;
  logic [bpa_pkg::CNT_W-1:0]        used_count;
  logic [bpa_pkg::CNT_W-1:0]        free_count;
  logic [bpa_pkg::CNT_W-1:0]        managed_count;
  modport source (output valid, result_addr, success, used_count, free_count,
                  managed_count, input ready);
  modport sink   (input valid, result_addr, success, used_count, free_count,
                  managed_count, output ready);
endinterface

interface bpa_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bpa_pkg::CFG_IDX_W-1:0]    index;
  logic [bpa_pkg::CNT_W-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/bitmap_page_allocator.sv
// First-fit physical page allocator over a one-bit-per-page map held in a word memory.
//
// Requests arrive on in_ch (mode, free_addr); each request gives exactly one
// result on out_ch. Registers managed_pages and reserved_pages are written on
// cfg_ch, which is always ready; the user must write them only while no request
// is in flight, as the block itself does not enforce this.
// Allocate reads the map one word per cycle and stops at the first word with a
// free page below the managed count. Free reads and writes back one word. Init
// writes every map word once, one per cycle. One request is in work at a time.
// After reset the block rebuilds the map with the reset register values, with
// in_ch not ready and no result.
// A finished result waits in the output register while the next request is
// taken; if the receiver stalls, the next result holds the block until the
// output register frees.
`timescale 1ns / 1ps

module bitmap_page_allocator #(
  parameter int PAGES      = bpa_pkg::PAGES_DEF,
  parameter int WORD_BITS  = bpa_pkg::WORD_BITS_DEF,
  parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bpa_in_if.sink      in_ch,
  bpa_out_if.source   out_ch,
  bpa_cfg_if.sink     cfg_ch
);

  localparam int WB        = WORD_BITS;
  localparam int BW        = $clog2(WB);
  localparam int MAP_WORDS = (PAGES + WB - 1) / WB;
  localparam int IW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CW        = $clog2(MAP_WORDS + 1);
  localparam int UW        = $clog2(PAGES + 1);
  localparam int EW        = (UW > bpa_pkg::CNT_W) ? UW : bpa_pkg::CNT_W;
  localparam int PW        = UW + BW + 1;
  localparam int AW        = bpa_pkg::ADDR_W;

  function automatic logic [WB-1:0] span_mask(input logic [UW-1:0] lim,
                                               input logic [IW-1:0] k);
    logic [PW-1:0] base;
    logic [PW-1:0] diff;
    logic [WB-1:0] m;
    base = PW'(k) << BW;
    diff = PW'(lim) - base;
    if (PW'(lim) <= base) begin
      m = '0;
    end else if (diff >= PW'(WB)) begin
      m = '1;
    end else begin
      m = ~({WB{1'b1}} << diff[BW-1:0]);
    end
    return m;
  endfunction

  function automatic logic [BW-1:0] bit_index(input logic [WB-1:0] oh);
    logic [BW-1:0] r;
    r = '0;
    for (int j = 0; j < BW; j++) begin
      for (int i = 0; i < WB; i++) begin
        if (((i >> j) & 1) == 1) begin
          r[j] = r[j] | oh[i];
        end
      end
    end
    return r;
  endfunction

  logic [WB-1:0] mem [MAP_WORDS];
  logic [WB-1:0] mem_q;
  logic          mem_we;
  logic          mem_re;
  logic [IW-1:0] mem_wa;
  logic [IW-1:0] mem_ra;
  logic [WB-1:0] mem_wd;

  bpa_pkg::state_t            state_r, state_nxt;
  logic [CW-1:0]              idx_r, idx_nxt;
  logic [IW-1:0]              chk_r, chk_nxt;
  logic                       chk_vld_r, chk_vld_nxt;
  logic                       req_r, req_nxt;
  logic [UW-1:0]              used_r, used_nxt;
  logic [BW-1:0]              fr_bit_r, fr_bit_nxt;
  logic [AW-1:0]              pend_addr_r, pend_addr_nxt;
  logic                       pend_ok_r, pend_ok_nxt;
  logic [bpa_pkg::CNT_W-1:0]  managed_r, reserved_r;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_load;
  logic [AW-1:0]              out_addr_r;
  logic                       out_ok_r;
  logic [bpa_pkg::CNT_W-1:0]  out_used_r, out_free_r, out_managed_r;

  logic [UW-1:0]   eff_n;
  logic [UW-1:0]   rsv_n;
  logic [CW-1:0]   n_words;
  logic [AW-1:0]   free_pg;
  logic [WB-1:0]   free_bits;
  logic [WB-1:0]   low_bit;
  logic [IW+BW-1:0] alloc_pg;
  logic [63:0]     alloc_byte;

  assign eff_n = (EW'(managed_r) > EW'(PAGES)) ? UW'(PAGES) : UW'(managed_r);
  assign rsv_n = (EW'(reserved_r) > EW'(eff_n)) ? eff_n : UW'(reserved_r);
  assign n_words = CW'(((UW + 1)'(eff_n) + (UW + 1)'(WB - 1)) >> BW);
  assign free_pg = in_ch.free_addr >> PAGE_SHIFT;
  assign free_bits = ~mem_q & span_mask(eff_n, chk_r);
  assign low_bit = free_bits & (~free_bits + WB'(1));
  assign alloc_pg = {chk_r, bit_index(low_bit)};
  assign alloc_byte = 64'(alloc_pg) << PAGE_SHIFT;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      managed_r  <= bpa_pkg::RST_MANAGED;
      reserved_r <= bpa_pkg::RST_RESERVED;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        bpa_pkg::CFG_MANAGED:  managed_r  <= cfg_ch.data;
        bpa_pkg::CFG_RESERVED: reserved_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpa_pkg::S_INIT;
      idx_r       <= '0;
      chk_vld_r   <= 1'b0;
      req_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      req_r       <= req_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r       <= chk_nxt;
    used_r      <= used_nxt;
    fr_bit_r    <= fr_bit_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_ok_r   <= pend_ok_nxt;
    if (out_load) begin
      out_addr_r    <= pend_addr_r;
      out_ok_r      <= pend_ok_r;
      out_used_r    <= bpa_pkg::CNT_W'(used_r);
      out_free_r    <= (eff_n > used_r) ? bpa_pkg::CNT_W'(eff_n - used_r) : '0;
      out_managed_r <= bpa_pkg::CNT_W'(eff_n);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    chk_nxt       = chk_r;
    chk_vld_nxt   = 1'b0;
    req_nxt       = req_r;
    used_nxt      = used_r;
    fr_bit_nxt    = fr_bit_r;
    pend_addr_nxt = pend_addr_r;
    pend_ok_nxt   = pend_ok_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    mem_we        = 1'b0;
    mem_wa        = chk_r;
    mem_wd        = '0;
    mem_re        = 1'b0;
    mem_ra        = idx_r[IW-1:0];
    in_ch.ready   = 1'b0;

    case (state_r)
      bpa_pkg::S_INIT: begin
        mem_we  = 1'b1;
        mem_wa  = idx_r[IW-1:0];
        mem_wd  = span_mask(rsv_n, idx_r[IW-1:0]);
        idx_nxt = idx_r + CW'(1);
        if (idx_r == CW'(MAP_WORDS - 1)) begin
          used_nxt  = rsv_n;
          state_nxt = req_r ? bpa_pkg::S_DONE : bpa_pkg::S_IDLE;
        end
      end
      bpa_pkg::S_IDLE: begin
        in_ch.ready   = 1'b1;
        pend_addr_nxt = '0;
        pend_ok_nxt   = 1'b0;
        if (in_ch.valid) begin
          case (in_ch.mode)
            bpa_pkg::MODE_ALLOC: begin
              idx_nxt   = '0;
              state_nxt = (n_words == '0) ? bpa_pkg::S_DONE : bpa_pkg::S_SCAN;
            end
            bpa_pkg::MODE_FREE: begin
              if (free_pg < AW'(eff_n)) begin
                mem_re      = 1'b1;
                mem_ra      = free_pg[BW +: IW];
                chk_nxt     = free_pg[BW +: IW];
                fr_bit_nxt  = free_pg[BW-1:0];
                pend_ok_nxt = 1'b1;
                state_nxt   = bpa_pkg::S_FREE_WR;
              end else begin
                state_nxt = bpa_pkg::S_DONE;
              end
            end
            bpa_pkg::MODE_INIT: begin
              idx_nxt     = '0;
              req_nxt     = 1'b1;
              pend_ok_nxt = 1'b1;
              state_nxt   = bpa_pkg::S_INIT;
            end
            default: state_nxt = bpa_pkg::S_DONE;
          endcase
        end
      end
      bpa_pkg::S_SCAN: begin
        if (idx_r < n_words) begin
          mem_re      = 1'b1;
          chk_nxt     = idx_r[IW-1:0];
          chk_vld_nxt = 1'b1;
          idx_nxt     = idx_r + CW'(1);
        end
        if (chk_vld_r) begin
          if (|free_bits) begin
            mem_we        = 1'b1;
            mem_wd        = mem_q | low_bit;
            used_nxt      = used_r + UW'(1);
            pend_addr_nxt = alloc_byte[AW-1:0];
            pend_ok_nxt   = 1'b1;
            chk_vld_nxt   = 1'b0;
            state_nxt     = bpa_pkg::S_DONE;
          end else if (CW'(chk_r) + CW'(1) == n_words) begin
            chk_vld_nxt = 1'b0;
            state_nxt   = bpa_pkg::S_DONE;
          end
        end
      end
      bpa_pkg::S_FREE_WR: begin
        if (mem_q[fr_bit_r]) begin
          mem_we = 1'b1;
          mem_wd = mem_q & ~(WB'(1) << fr_bit_r);
          if (used_r != '0) begin
            used_nxt = used_r - UW'(1);
          end
        end
        state_nxt = bpa_pkg::S_DONE;
      end
      bpa_pkg::S_DONE: begin
        req_nxt = 1'b0;
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = bpa_pkg::S_IDLE;
        end
      end
      default: state_nxt = bpa_pkg::S_IDLE;
    endcase
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_addr   = out_addr_r;
  assign out_ch.success       = out_ok_r;
  assign out_ch.used_count    = out_used_r;
  assign out_ch.free_count    = out_free_r;
  assign out_ch.managed_count = out_managed_r;

endmodule
